// ===== rtl/core/bit_packed_prime_sieve_top_assert.svh =====
// Assertion macros for the prime sieve top level.
`ifndef BIT_PACKED_PRIME_SIEVE_TOP_ASSERT_SVH
`define BIT_PACKED_PRIME_SIEVE_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk_i, idle in reset.
`define BPPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, idle in reset.
`define BPPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPPS_ASSERT_NOW(label, ante, cons, msg)
`define BPPS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/bpps_pkg.sv =====
// Shared types and constants for the bit-packed prime sieve.
package bpps_pkg;

  localparam int unsigned NUM_W   = 16;  // numbers and limit
  localparam int unsigned COUNT_W = 13;  // prime count
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 9;   // outer sieve index, up to 256
  localparam int unsigned SQ_W    = 17;  // i*i and marking cursor
  localparam int unsigned BIDX_W  = NUM_W - 3;  // byte index in number space

  localparam logic [NUM_W-1:0]  SIEVE_LIMIT_RST = 16'hFFFF;
  localparam logic [BYTE_W-1:0] BYTE_LSB        = 8'h01;
  localparam logic [2:0]        BIT_SEL_MASK    = 3'h7;
  localparam logic [BYTE_W-1:0] LOW_KEEP_MASK   = 8'h07;

  // Operation codes of an input beat.
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register word index on the config port.
  localparam logic REG_SIEVE_LIMIT = 1'b0;

  typedef struct packed {
    logic             operation;
    logic [NUM_W-1:0] query_value;
  } bpps_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] prime_count;
    logic               is_prime;
    logic               out_of_range;
  } bpps_out_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLR,
    DP_SV_RD,
    DP_SV_NEXT,
    DP_MK_INIT,
    DP_MK_RD,
    DP_MK_WR,
    DP_CNT_RD,
    DP_CNT_ACC,
    DP_Q_RD
  } bpps_dp_op_e;

  typedef struct packed {
    bpps_dp_op_e op;
    logic        load_in;
    logic        load_out;
  } bpps_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sq_gt_lim;
    logic i_comp;
    logic j_gt_lim;
    logic cnt_last;
  } bpps_sts_t;

endpackage

// ===== rtl/core/bpps_dp.sv =====
// Datapath: composite map memory, sieve cursors, prime counter, result register.
module bpps_dp import bpps_pkg::*; #(
  parameter int unsigned MAX_LIMIT = 65535
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bpps_cmd_t        cmd_i,
  input  logic [NUM_W-1:0] lim_i,
  input  bpps_in_t         in_data_i,
  output bpps_sts_t        sts_o,
  output bpps_out_t        out_data_o
);

  localparam int unsigned MAP_BYTES = (MAX_LIMIT / 8) + 1;
  localparam int unsigned AW        = $clog2(MAP_BYTES);

  logic [BYTE_W-1:0] mem_q [MAP_BYTES];
  logic [BYTE_W-1:0] rdata_q;

  logic [AW-1:0]      clr_idx_q, clr_idx_d;
  logic [IDX_W-1:0]   i_q;
  logic [SQ_W-1:0]    sq_q, j_q;
  logic [BIDX_W-1:0]  b_q;
  logic [COUNT_W-1:0] count_q;
  bpps_in_t           item_q;
  bpps_out_t          out_q, out_d;

  logic              re, we;
  logic [AW-1:0]     raddr, waddr;
  logic [BYTE_W-1:0] wdata;
  logic [BYTE_W-1:0] cnt_mask, live;
  logic              q_oor;

  function automatic logic [3:0] popcnt8(input logic [BYTE_W-1:0] v);
    logic [3:0] s;
    s = '0;
    for (int k = 0; k < BYTE_W; k++) s = s + 4'(v[k]);
    return s;
  endfunction

  assign q_oor = item_q.query_value > lim_i;

  // Count window: all bits but 0 and 1 of byte 0 and but those above the limit in the last byte.
  always_comb begin
    cnt_mask = '1;
    if (b_q == '0) cnt_mask = cnt_mask & ~(LOW_KEEP_MASK >> 1);
    if (b_q == lim_i[NUM_W-1:3]) cnt_mask = cnt_mask & (8'hFF >> (BIT_SEL_MASK - lim_i[2:0]));
    live = ~rdata_q & cnt_mask;
  end

  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = '0;
    waddr = '0;
    wdata = '0;
    unique case (cmd_i.op)
      DP_CLR: begin
        we    = 1'b1;
        waddr = clr_idx_q;
      end
      DP_SV_RD: begin
        re    = 1'b1;
        raddr = AW'(i_q >> 3);
      end
      DP_MK_RD: begin
        re    = 1'b1;
        raddr = AW'(j_q >> 3);
      end
      DP_MK_WR: begin
        we    = 1'b1;
        waddr = AW'(j_q >> 3);
        wdata = rdata_q | (BYTE_LSB << j_q[2:0]);
      end
      DP_CNT_RD: begin
        re    = 1'b1;
        raddr = AW'(b_q);
      end
      DP_CNT_ACC: begin
        // number 1 is marked non-prime while byte 0 passes by
        we    = (b_q == '0);
        waddr = '0;
        wdata = rdata_q | (BYTE_LSB << 1);
      end
      DP_Q_RD: begin
        re    = 1'b1;
        raddr = AW'(item_q.query_value >> 3);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  assign clr_idx_d = sts_o.clr_last ? '0 : clr_idx_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.op == DP_CLR) begin
      clr_idx_q <= clr_idx_d;
    end
  end

  always_comb begin
    out_d = '0;
    if (item_q.operation == OP_BUILD) begin
      out_d.prime_count = count_q;
    end else if (q_oor) begin
      out_d.out_of_range = 1'b1;
    end else begin
      out_d.is_prime = ~rdata_q[item_q.query_value[2:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) item_q <= in_data_i;
    unique case (cmd_i.op)
      DP_CLR: begin
        i_q     <= IDX_W'(2);
        sq_q    <= SQ_W'(4);
        b_q     <= '0;
        count_q <= '0;
      end
      DP_SV_NEXT: begin
        i_q  <= i_q + IDX_W'(1);
        sq_q <= sq_q + SQ_W'({i_q, 1'b1});
      end
      DP_MK_INIT: j_q <= sq_q;
      DP_MK_WR:   j_q <= j_q + SQ_W'(i_q);
      DP_CNT_ACC: begin
        count_q <= count_q + COUNT_W'(popcnt8(live));
        b_q     <= b_q + BIDX_W'(1);
      end
      default: ;
    endcase
    if (cmd_i.load_out) out_q <= out_d;
  end

  assign sts_o.clr_last  = (clr_idx_q == AW'(MAP_BYTES - 1));
  assign sts_o.sq_gt_lim = sq_q > SQ_W'(lim_i);
  assign sts_o.i_comp    = rdata_q[i_q[2:0]];
  assign sts_o.j_gt_lim  = j_q > SQ_W'(lim_i);
  assign sts_o.cnt_last  = (b_q == lim_i[NUM_W-1:3]);

  assign out_data_o = out_q;

endmodule

// ===== rtl/core/bpps_ctrl.sv =====
// Controller: sequences clear, sieve, count and query phases; owns the output valid.
module bpps_ctrl import bpps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_op_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  bpps_sts_t sts_i,
  output bpps_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SV_CHK,
    S_SV_TST,
    S_MK_RD,
    S_MK_WR,
    S_CNT_RD,
    S_CNT_ACC,
    S_Q_RD,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   boot_q, boot_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    boot_d        = boot_q;
    cmd_o.op      = DP_NOP;
    cmd_o.load_in = 1'b0;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.op = DP_CLR;
        if (sts_i.clr_last) begin
          boot_d  = 1'b0;
          state_d = boot_q ? S_IDLE : S_SV_CHK;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = (in_op_i == OP_BUILD) ? S_CLR : S_Q_RD;
        end
      end
      S_SV_CHK: begin
        cmd_o.op = DP_SV_RD;
        state_d  = sts_i.sq_gt_lim ? S_CNT_RD : S_SV_TST;
      end
      S_SV_TST: begin
        cmd_o.op = sts_i.i_comp ? DP_SV_NEXT : DP_MK_INIT;
        state_d  = sts_i.i_comp ? S_SV_CHK : S_MK_RD;
      end
      S_MK_RD: begin
        cmd_o.op = sts_i.j_gt_lim ? DP_SV_NEXT : DP_MK_RD;
        state_d  = sts_i.j_gt_lim ? S_SV_CHK : S_MK_WR;
      end
      S_MK_WR: begin
        cmd_o.op = DP_MK_WR;
        state_d  = S_MK_RD;
      end
      S_CNT_RD: begin
        cmd_o.op = DP_CNT_RD;
        state_d  = S_CNT_ACC;
      end
      S_CNT_ACC: begin
        cmd_o.op = DP_CNT_ACC;
        state_d  = sts_i.cnt_last ? S_RESP : S_CNT_RD;
      end
      S_Q_RD: begin
        cmd_o.op = DP_Q_RD;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      boot_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      boot_q      <= boot_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/bit_packed_prime_sieve_top.sv =====
// Top level of the bit-packed prime sieve: config register, controller and datapath.
// Sieve of Eratosthenes over a composite map of one bit per number, eight numbers
// to a byte in a MAX_LIMIT/8+1 byte memory. A build beat (operation 0) clears the
// map, sieves 2..limit and returns the prime count; a query beat (operation 1)
// returns whether a number's bit is clear, or out_of_range above the limit. The
// limit is min(sieve_limit, MAX_LIMIT). Timing: after reset the block clears the
// memory, one byte per cycle, before taking its first beat. A query makes one
// memory read. A build clears the map, reads the byte of each sieve candidate up
// to sqrt(limit), takes one more step per prime to close its marking run, marks
// each multiple by a read-modify-write of the map memory, and reads and sums
// each of the limit/8+1 count bytes; marking dominates. One item is in flight
// at a time; the result register lets the next beat in while a result waits
// downstream.
`include "bit_packed_prime_sieve_top_assert.svh"

module bit_packed_prime_sieve_top import bpps_pkg::*; #(
  parameter int unsigned MAX_LIMIT = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  bpps_in_t    in_data_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output bpps_out_t   out_data_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Cap of the effective limit, kept within the 16-bit number space.
  localparam int unsigned NUM_MAX = (2 ** NUM_W) - 1;
  localparam int unsigned LIM_CAP = (MAX_LIMIT < NUM_MAX) ? MAX_LIMIT : NUM_MAX;

  logic [NUM_W-1:0] sieve_limit_q, sieve_limit_d;
  logic [NUM_W-1:0] lim;
  logic             cfg_wr;
  bpps_cmd_t        cmd;
  bpps_sts_t        sts;

  // Config register: single word, written on the APB access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIEVE_LIMIT);
  assign sieve_limit_d = cfg_wr ? pwdata[NUM_W-1:0] : sieve_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sieve_limit_q <= SIEVE_LIMIT_RST;
    end else begin
      sieve_limit_q <= sieve_limit_d;
    end
  end

  assign prdata = (paddr[2] == REG_SIEVE_LIMIT) ? 32'(sieve_limit_q) : '0;

  // Saturate to the map size; the user must keep it stable while an item is in flight, the block does not enforce it.
  assign lim = (sieve_limit_q > NUM_W'(LIM_CAP)) ? NUM_W'(LIM_CAP) : sieve_limit_q;

  bpps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.operation),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpps_dp #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .lim_i      (lim),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // An accepted beat keeps the block busy for at least the next cycle.
  `BPPS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")
  // Out of range results carry no prime flag and no count.
  `BPPS_ASSERT_NOW(a_oor_clean, out_valid_o && out_data_o.out_of_range, !out_data_o.is_prime && (out_data_o.prime_count == '0), "out of range result not clean")
  // A new result only appears while an item was being worked on.
  `BPPS_ASSERT_NOW(a_result_from_work, $rose(out_valid_o), $past(in_stall_o), "result without work")

endmodule
